// ===== src/mtat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle tracker package
// Shared constants, configuration register indexes, the microcode word type
// and the microcode program of the angle tracker.
// ----------------------------------------------------------------------------
package mtat_pkg;

    // Default encoder resolution, counts per rotor turn
    localparam int COUNTS_PER_TURN_DEF = 8192;

    // One full circle in 1/65536 degree
    localparam int          FULL_W      = 25;
    localparam logic [24:0] FULL_CIRCLE = 25'd23592960;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 8;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [7:0]  CFG_MOTOR_KIND  = 8'd0;
    localparam logic [7:0]  CFG_RATIO       = 8'd1;
    localparam logic [7:0]  CFG_WRAP_HIGH   = 8'd2;
    localparam logic [7:0]  CFG_WRAP_LOW    = 8'd3;

    // Configuration reset values
    localparam logic [1:0]  KIND_RST      = 2'd1;
    localparam logic [7:0]  RATIO_RST     = 8'd19;
    localparam logic [12:0] WRAP_HIGH_RST = 13'd6700;
    localparam logic [12:0] WRAP_LOW_RST  = 13'd1500;

    // Motor kinds
    localparam logic [1:0]  KIND_NONE   = 2'd0;
    localparam logic [1:0]  KIND_GEARED = 2'd1;
    localparam logic [1:0]  KIND_DIRECT = 2'd2;

    // Crossing codes
    localparam logic [1:0]  WRAP_NONE = 2'd0;
    localparam logic [1:0]  WRAP_FWD  = 2'd1;
    localparam logic [1:0]  WRAP_REV  = 2'd2;

    // Datapath operations
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_TAKE  = 4'd1;
    localparam logic [3:0] OP_FRONT = 4'd2;
    localparam logic [3:0] OP_TURN  = 4'd3;
    localparam logic [3:0] OP_RLOAD = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_RFIX  = 4'd6;
    localparam logic [3:0] OP_ALOAD = 4'd7;
    localparam logic [3:0] OP_AMUL  = 4'd8;
    localparam logic [3:0] OP_BLOAD = 4'd9;
    localparam logic [3:0] OP_STORE = 4'd10;
    localparam logic [3:0] OP_EMIT  = 4'd11;

    // Jump conditions
    localparam logic [2:0] C_NEVER   = 3'd0;
    localparam logic [2:0] C_ALWAYS  = 3'd1;
    localparam logic [2:0] C_IDLE    = 3'd2;
    localparam logic [2:0] C_IGNORE  = 3'd3;
    localparam logic [2:0] C_WRAP    = 3'd4;
    localparam logic [2:0] C_DIRECT  = 3'd5;
    localparam logic [2:0] C_MORE    = 3'd6;
    localparam logic [2:0] C_OUTFULL = 3'd7;

    // Program step addresses
    localparam int         PC_W     = 4;
    localparam logic [3:0] ST_WAIT  = 4'd0;
    localparam logic [3:0] ST_FRONT = 4'd1;
    localparam logic [3:0] ST_TURN  = 4'd2;
    localparam logic [3:0] ST_KIND  = 4'd3;
    localparam logic [3:0] ST_RLOAD = 4'd4;
    localparam logic [3:0] ST_RDIV  = 4'd5;
    localparam logic [3:0] ST_RFIX  = 4'd6;
    localparam logic [3:0] ST_ALOAD = 4'd7;
    localparam logic [3:0] ST_ADIV  = 4'd8;
    localparam logic [3:0] ST_AMUL  = 4'd9;
    localparam logic [3:0] ST_BLOAD = 4'd10;
    localparam logic [3:0] ST_BDIV  = 4'd11;
    localparam logic [3:0] ST_STORE = 4'd12;
    localparam logic [3:0] ST_EMIT  = 4'd13;
    localparam logic [3:0] ST_BACK  = 4'd14;

    // Loop lengths of the divider passes
    localparam logic [4:0] ROTOR_STEPS = 5'd9;
    localparam logic [4:0] FOLD_STEPS  = 5'd9;
    localparam logic [4:0] ANGLE_STEPS = 5'd25;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [3:0] target;
    } t_uword;

    // Control store: jump to target when cond holds, else fall through
    function automatic t_uword ucode(input logic [3:0] pc);
        t_uword w;
        case (pc)
            ST_WAIT:  w = '{op: OP_TAKE,  cond: C_IDLE,    target: ST_WAIT};
            ST_FRONT: w = '{op: OP_FRONT, cond: C_IGNORE,  target: ST_EMIT};
            ST_TURN:  w = '{op: OP_TURN,  cond: C_WRAP,    target: ST_EMIT};
            ST_KIND:  w = '{op: OP_NOP,   cond: C_DIRECT,  target: ST_ALOAD};
            ST_RLOAD: w = '{op: OP_RLOAD, cond: C_NEVER,   target: ST_WAIT};
            ST_RDIV:  w = '{op: OP_DIV,   cond: C_MORE,    target: ST_RDIV};
            ST_RFIX:  w = '{op: OP_RFIX,  cond: C_NEVER,   target: ST_WAIT};
            ST_ALOAD: w = '{op: OP_ALOAD, cond: C_NEVER,   target: ST_WAIT};
            ST_ADIV:  w = '{op: OP_DIV,   cond: C_MORE,    target: ST_ADIV};
            ST_AMUL:  w = '{op: OP_AMUL,  cond: C_NEVER,   target: ST_WAIT};
            ST_BLOAD: w = '{op: OP_BLOAD, cond: C_NEVER,   target: ST_WAIT};
            ST_BDIV:  w = '{op: OP_DIV,   cond: C_MORE,    target: ST_BDIV};
            ST_STORE: w = '{op: OP_STORE, cond: C_NEVER,   target: ST_WAIT};
            ST_EMIT:  w = '{op: OP_EMIT,  cond: C_OUTFULL, target: ST_EMIT};
            ST_BACK:  w = '{op: OP_NOP,   cond: C_ALWAYS,  target: ST_WAIT};
            default:  w = '{op: OP_NOP,   cond: C_ALWAYS,  target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== src/mtat_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle tracker channels
// Frame input, result output and configuration write channels, each a
// valid/ready handshake with a source and a sink side.
// ----------------------------------------------------------------------------
interface mtat_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] angle_high_byte;
    logic [7:0] angle_low_byte;
    logic [7:0] speed_high_byte;
    logic [7:0] speed_low_byte;
    logic [7:0] current_high_byte;
    logic [7:0] current_low_byte;

    modport source (
        output valid, angle_high_byte, angle_low_byte, speed_high_byte,
               speed_low_byte, current_high_byte, current_low_byte,
        input  ready
    );
    modport sink (
        input  valid, angle_high_byte, angle_low_byte, speed_high_byte,
               speed_low_byte, current_high_byte, current_low_byte,
        output ready
    );
endinterface

interface mtat_result_if;
    logic               valid;
    logic               ready;
    logic               frame_taken;
    logic [24:0]        shaft_angle;
    logic               angle_updated;
    logic [1:0]         wrap_event;
    logic signed [15:0] speed_value;
    logic signed [15:0] current_value;
    logic signed [8:0]  rotor_turn_count;
    logic signed [31:0] shaft_turn_count;
    logic [31:0]        frames_seen;

    modport source (
        output valid, frame_taken, shaft_angle, angle_updated, wrap_event,
               speed_value, current_value, rotor_turn_count, shaft_turn_count,
               frames_seen,
        input  ready
    );
    modport sink (
        input  valid, frame_taken, shaft_angle, angle_updated, wrap_event,
               speed_value, current_value, rotor_turn_count, shaft_turn_count,
               frames_seen,
        output ready
    );
endinterface

interface mtat_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mtat_pkg::CFG_IDX_W-1:0]  index;
    logic [mtat_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/multiturn_encoder_angle_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-turn encoder angle tracker
// Unpacks motor feedback frames, tracks rotor and shaft turns across encoder
// wraps and computes the output shaft angle through a gear reduction.
// ----------------------------------------------------------------------------
// Usage:
//   i_frame takes one six-byte feedback word; o_result gives one result word
//   per frame; i_cfg writes motor kind, ratio and the two wrap levels and is
//   always ready. Write configuration only while no frame is in flight.
//   A small microcoded sequencer runs each frame through a shared restoring
//   divider, one quotient bit per cycle. Steps from frame to result:
//     geared, no crossing : rotor fold, count fold and angle divide passes
//     direct, no crossing : count fold and angle divide passes
//     crossing or ignored : straight to the result word
//   After the emit step a return step leads back to the wait step, and only
//   there does the block take a new frame. A finished word sits in the output
//   register; the block takes the next frame while it waits, and holds its
//   next result until the receiver takes the old one. Reset clears all turn
//   counts, the held angle and the frame count and loads the default
//   configuration (geared, ratio 19, wrap levels 6700 and 1500).
// ----------------------------------------------------------------------------
module multiturn_encoder_angle_tracker #(
    parameter int COUNTS_PER_TURN = mtat_pkg::COUNTS_PER_TURN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mtat_frame_if.sink         i_frame,
    mtat_cfg_if.sink           i_cfg,
    mtat_result_if.source      o_result
);

    localparam int FW     = mtat_pkg::FULL_W;
    // denominator counts-per-turn * ratio, and the widest raw count value
    localparam int DEN_W  = $clog2(COUNTS_PER_TURN * 255 + 1);
    localparam int CNT_W  = $clog2(COUNTS_PER_TURN * 255 + 65536);
    localparam int PROD_W = DEN_W + FW;

    // configuration
    logic [1:0]  r_kind;
    logic [7:0]  r_ratio;
    logic [12:0] r_wrap_high;
    logic [12:0] r_wrap_low;

    // latched frame
    logic [15:0] r_raw_in;
    logic [15:0] r_speed;
    logic [15:0] r_current;

    // tracker state
    logic [15:0] r_last_angle;
    logic [15:0] r_cur_angle;
    logic        r_seen_first;
    logic [8:0]  r_rotor;
    logic [31:0] r_shaft;
    logic [24:0] r_held;
    logic [31:0] r_frames;

    // per-frame flags
    logic        r_taken;
    logic        r_updated;
    logic [1:0]  r_wrap;
    logic        r_neg;

    // divider datapath
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [FW-1:0]     r_dvd;
    logic [FW-1:0]     r_quo;
    logic [4:0]        r_cnt;
    logic [PROD_W-1:0] r_prod;

    // sequencer
    logic [mtat_pkg::PC_W-1:0] r_pc;
    logic [mtat_pkg::PC_W-1:0] n_pc;
    mtat_pkg::t_uword          w_uw;

    // output register
    logic        r_out_valid;
    logic        r_o_taken;
    logic [24:0] r_o_angle;
    logic        r_o_updated;
    logic [1:0]  r_o_wrap;
    logic [15:0] r_o_speed;
    logic [15:0] r_o_current;
    logic [8:0]  r_o_rotor;
    logic [31:0] r_o_shaft;
    logic [31:0] r_o_frames;

    logic              w_accept;
    logic              w_out_free;
    logic              w_cond;
    logic              w_kind_ok;
    logic [7:0]        w_q;
    logic [15:0]       w_raw;
    logic [15:0]       w_prev;
    logic [1:0]        w_wrap;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;
    logic [DEN_W:0]    w_diff;
    logic [8:0]        w_rneg;
    logic [8:0]        w_fold;
    logic [7:0]        w_turns;
    logic [CNT_W-1:0]  w_counts;

    assign w_uw       = mtat_pkg::ucode(r_pc);
    assign i_frame.ready = (r_pc == mtat_pkg::ST_WAIT);
    assign w_accept   = i_frame.valid && i_frame.ready;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign i_cfg.ready = 1'b1;

    assign w_kind_ok = (r_kind == mtat_pkg::KIND_GEARED) ||
                       (r_kind == mtat_pkg::KIND_DIRECT);
    // a zero ratio behaves as one
    assign w_q       = (r_ratio == 8'd0) ? 8'd1 : r_ratio;

    // crossing detect on the latched angle
    assign w_raw  = r_raw_in;
    assign w_prev = r_seen_first ? r_cur_angle : w_raw;
    always_comb begin
        if (w_raw > {3'b000, r_wrap_high} && w_prev < {3'b000, r_wrap_low}) begin
            w_wrap = mtat_pkg::WRAP_REV;
        end else if (w_raw < {3'b000, r_wrap_low} && w_prev > {3'b000, r_wrap_high}) begin
            w_wrap = mtat_pkg::WRAP_FWD;
        end else begin
            w_wrap = mtat_pkg::WRAP_NONE;
        end
    end

    // one restoring divide step: shift in the next dividend bit, subtract
    assign w_trial = {r_rem, r_dvd[FW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // negative rotor count: fold ceil(-r/q) turns back out of it
    assign w_rneg  = 9'd0 - r_rotor;
    assign w_fold  = r_rotor[8] ? (w_rneg + 9'(w_q) - 9'd1) : r_rotor;

    // rotor count is already within 0..ratio-1 here
    assign w_turns  = (r_kind == mtat_pkg::KIND_GEARED) ? r_rotor[7:0] : 8'd0;
    assign w_counts = CNT_W'(w_turns) * CNT_W'(COUNTS_PER_TURN) + CNT_W'(r_cur_angle);

    always_comb begin
        case (w_uw.cond)
            mtat_pkg::C_NEVER:   w_cond = 1'b0;
            mtat_pkg::C_ALWAYS:  w_cond = 1'b1;
            mtat_pkg::C_IDLE:    w_cond = !w_accept;
            mtat_pkg::C_IGNORE:  w_cond = !w_kind_ok;
            mtat_pkg::C_WRAP:    w_cond = (r_wrap != mtat_pkg::WRAP_NONE);
            mtat_pkg::C_DIRECT:  w_cond = (r_kind == mtat_pkg::KIND_DIRECT);
            mtat_pkg::C_MORE:    w_cond = (r_cnt != 5'd1);
            mtat_pkg::C_OUTFULL: w_cond = !w_out_free;
            default:             w_cond = 1'b0;
        endcase
        n_pc = w_cond ? w_uw.target : r_pc + 4'd1;
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= mtat_pkg::KIND_RST;
            r_ratio     <= mtat_pkg::RATIO_RST;
            r_wrap_high <= mtat_pkg::WRAP_HIGH_RST;
            r_wrap_low  <= mtat_pkg::WRAP_LOW_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                mtat_pkg::CFG_MOTOR_KIND: r_kind      <= i_cfg.data[1:0];
                mtat_pkg::CFG_RATIO:      r_ratio     <= i_cfg.data[7:0];
                mtat_pkg::CFG_WRAP_HIGH:  r_wrap_high <= i_cfg.data[12:0];
                mtat_pkg::CFG_WRAP_LOW:   r_wrap_low  <= i_cfg.data[12:0];
                default: ;
            endcase
        end
    end

    // sequencer, tracker state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= mtat_pkg::ST_WAIT;
            r_last_angle <= '0;
            r_cur_angle  <= '0;
            r_seen_first <= 1'b0;
            r_rotor      <= '0;
            r_shaft      <= '0;
            r_held       <= '0;
            r_frames     <= '0;
            r_taken      <= 1'b0;
            r_updated    <= 1'b0;
            r_wrap       <= mtat_pkg::WRAP_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc <= n_pc;
            // load the output register on emit, drop the word once taken
            if (w_uw.op == mtat_pkg::OP_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (w_uw.op)
                mtat_pkg::OP_TAKE: begin
                    if (w_accept) begin
                        r_raw_in  <= {i_frame.angle_high_byte, i_frame.angle_low_byte};
                        r_speed   <= {i_frame.speed_high_byte, i_frame.speed_low_byte};
                        r_current <= {i_frame.current_high_byte, i_frame.current_low_byte};
                    end
                end
                mtat_pkg::OP_FRONT: begin
                    // ignored frame leaves the tracker state alone and clears the per-frame flags
                    r_updated <= 1'b0;
                    if (w_kind_ok) begin
                        r_taken      <= 1'b1;
                        r_frames     <= r_frames + 32'd1;
                        r_last_angle <= w_prev;
                        r_cur_angle  <= w_raw;
                        r_seen_first <= 1'b1;
                        r_wrap       <= w_wrap;
                    end else begin
                        r_taken <= 1'b0;
                        r_wrap  <= mtat_pkg::WRAP_NONE;
                    end
                end
                mtat_pkg::OP_TURN: begin
                    if (r_kind == mtat_pkg::KIND_GEARED) begin
                        if (r_wrap == mtat_pkg::WRAP_REV) begin
                            r_rotor <= r_rotor - 9'd1;
                        end else if (r_wrap == mtat_pkg::WRAP_FWD) begin
                            r_rotor <= r_rotor + 9'd1;
                        end
                    end else begin
                        if (r_wrap == mtat_pkg::WRAP_REV) begin
                            r_shaft <= r_shaft - 32'd1;
                        end else if (r_wrap == mtat_pkg::WRAP_FWD) begin
                            r_shaft <= r_shaft + 32'd1;
                        end
                    end
                end
                mtat_pkg::OP_RLOAD: begin
                    r_neg <= r_rotor[8];
                    r_rem <= '0;
                    r_den <= DEN_W'(w_q);
                    r_dvd <= {w_fold, (FW-9)'(0)};
                    r_cnt <= mtat_pkg::ROTOR_STEPS;
                end
                mtat_pkg::OP_DIV: begin
                    r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_quo <= {r_quo[FW-2:0], w_ge};
                    r_dvd <= {r_dvd[FW-2:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                end
                mtat_pkg::OP_RFIX: begin
                    // carry whole output turns out of the rotor count
                    if (r_neg) begin
                        r_rotor <= 9'(w_q) - 9'd1 - 9'(r_rem[7:0]);
                        r_shaft <= r_shaft - 32'(r_quo[8:0]);
                    end else begin
                        r_rotor <= 9'(r_rem[7:0]);
                        r_shaft <= r_shaft + 32'(r_quo[8:0]);
                    end
                end
                mtat_pkg::OP_ALOAD: begin
                    // reduce the count modulo one full output turn first;
                    // the quotient stays under 512, so nine steps suffice
                    r_rem <= DEN_W'(w_counts >> 9);
                    r_dvd <= {w_counts[8:0], (FW-9)'(0)};
                    r_den <= DEN_W'(COUNTS_PER_TURN) * DEN_W'(w_q);
                    r_cnt <= mtat_pkg::FOLD_STEPS;
                end
                mtat_pkg::OP_AMUL: begin
                    r_prod <= PROD_W'(r_rem) * PROD_W'(mtat_pkg::FULL_CIRCLE);
                end
                mtat_pkg::OP_BLOAD: begin
                    // quotient is below one full circle, so the top part
                    // is already below the denominator
                    r_rem <= r_prod[PROD_W-1:FW];
                    r_dvd <= r_prod[FW-1:0];
                    r_cnt <= mtat_pkg::ANGLE_STEPS;
                end
                mtat_pkg::OP_STORE: begin
                    r_held    <= r_quo;
                    r_updated <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (w_uw.op == mtat_pkg::OP_EMIT && w_out_free) begin
            r_o_taken   <= r_taken;
            r_o_angle   <= r_held;
            r_o_updated <= r_updated;
            r_o_wrap    <= r_wrap;
            r_o_speed   <= r_taken ? r_speed : 16'd0;
            r_o_current <= r_taken ? r_current : 16'd0;
            r_o_rotor   <= r_rotor;
            r_o_shaft   <= r_shaft;
            r_o_frames  <= r_frames;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.frame_taken      = r_o_taken;
    assign o_result.shaft_angle      = r_o_angle;
    assign o_result.angle_updated    = r_o_updated;
    assign o_result.wrap_event       = r_o_wrap;
    assign o_result.speed_value      = $signed(r_o_speed);
    assign o_result.current_value    = $signed(r_o_current);
    assign o_result.rotor_turn_count = $signed(r_o_rotor);
    assign o_result.shaft_turn_count = $signed(r_o_shaft);
    assign o_result.frames_seen      = r_o_frames;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle tracker testbench
// Drives feedback frames into the tracker and checks every result word
// against a cycle-free model of the turn counting and the shaft angle math
// that runs inside this bench. A short directed part covers the crossings,
// the wrap levels and the register extremes. Random encoder walks follow,
// under several gear ratios and both motor kinds. The sender idles in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          COUNTS          = mtat_pkg::COUNTS_PER_TURN_DEF;
    localparam int          WATCHDOG_LIMIT  = 5000;
    // Longest frame-to-result path (geared, no crossing) plus margin
    localparam int          LATENCY_TAIL    = 80;
    localparam int          SETTLE_CYCLES   = 4;
    // Spare motor kind, treated as no motor
    localparam logic [1:0]  KIND_SPARE      = 2'd3;
    // Register indexes that map to nothing
    localparam logic [7:0]  CFG_UNUSED_LO   = 8'd4;
    localparam logic [7:0]  CFG_UNUSED_HI   = 8'hFF;
    localparam logic [15:0] ALL_ONES        = 16'hFFFF;

    // One feedback frame as it appears on the wire
    typedef struct packed {
        logic [7:0] angle_hi;
        logic [7:0] angle_lo;
        logic [7:0] speed_hi;
        logic [7:0] speed_lo;
        logic [7:0] current_hi;
        logic [7:0] current_lo;
    } t_frame;

    // One result word
    typedef struct {
        logic               taken;
        logic [24:0]        angle;
        logic               updated;
        logic [1:0]         wrap;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic signed [8:0]  rotor;
        logic signed [31:0] shaft;
        logic [31:0]        frames;
    } t_tracker_word;

    logic clk = 1'b0;
    logic rst_n;

    mtat_frame_if  frame_ch ();
    mtat_cfg_if    cfg_ch ();
    mtat_result_if res_ch ();

    multiturn_encoder_angle_tracker dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_frame  (frame_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Tracker model state: configuration copy and turn bookkeeping
    // ------------------------------------------------------------------
    logic [1:0]         kind_reg;
    logic [7:0]         ratio_reg;
    logic [12:0]        high_reg;
    logic [12:0]        low_reg;

    logic [15:0]        angle_now;
    logic               seen_first;
    logic signed [8:0]  rotor_turns;
    logic signed [31:0] shaft_turns;
    logic [24:0]        held_angle;
    logic [31:0]        frame_count;

    t_tracker_word      expected_words[$];
    int                 mismatches = 0;

    // Stimulus shaping
    logic               sender_bursty   = 1'b1;
    logic               receiver_stalls = 1'b1;
    int                 burst_left      = 0;
    int                 walk_pos        = 0;

    // Receiver stall pattern and watchdog
    logic [15:0]        stall_lfsr  = 16'hACE1;
    logic [31:0]        cycle_count = '0;
    int                 quiet_cycles = 0;

    // Output angle in 1/65536 degree for a given rotor turn and raw angle
    function automatic logic [24:0] shaft_angle_of(input int turns,
                                                   input logic [15:0] raw,
                                                   input int q);
        longint unsigned counts;
        longint unsigned num;
        longint unsigned den;
        counts = longint'(turns) * longint'(COUNTS) + longint'(raw);
        num    = counts * longint'(mtat_pkg::FULL_CIRCLE);
        den    = longint'(COUNTS) * longint'(q);
        return 25'((num / den) % longint'(mtat_pkg::FULL_CIRCLE));
    endfunction

    function automatic t_frame make_frame(input logic [15:0] angle,
                                          input logic [15:0] speed,
                                          input logic [15:0] current);
        return '{angle[15:8], angle[7:0], speed[15:8], speed[7:0],
                 current[15:8], current[7:0]};
    endfunction

    // Advance the model by one accepted frame and queue the word it yields
    task automatic track_frame(input t_frame f);
        t_tracker_word w;
        logic [15:0]   raw;
        logic [15:0]   prev;
        int            r;
        int            q;
        int            k;
        w.taken   = 1'b0;
        w.updated = 1'b0;
        w.wrap    = mtat_pkg::WRAP_NONE;
        w.speed   = '0;
        w.current = '0;
        if (kind_reg == mtat_pkg::KIND_GEARED || kind_reg == mtat_pkg::KIND_DIRECT) begin
            raw         = {f.angle_hi, f.angle_lo};
            w.taken     = 1'b1;
            w.speed     = {f.speed_hi, f.speed_lo};
            w.current   = {f.current_hi, f.current_lo};
            frame_count = frame_count + 1;
            // First frame: no previous angle, so the raw angle stands in for it
            prev        = seen_first ? angle_now : raw;
            angle_now   = raw;
            seen_first  = 1'b1;
            if (raw > high_reg && prev < low_reg) begin
                w.wrap = mtat_pkg::WRAP_REV;
            end else if (raw < low_reg && prev > high_reg) begin
                w.wrap = mtat_pkg::WRAP_FWD;
            end
            // A zero ratio counts as one
            q = (ratio_reg == 8'd0) ? 1 : int'(ratio_reg);
            if (kind_reg == mtat_pkg::KIND_GEARED) begin
                case (w.wrap)
                    mtat_pkg::WRAP_REV: rotor_turns = rotor_turns - 9'sd1;
                    mtat_pkg::WRAP_FWD: rotor_turns = rotor_turns + 9'sd1;
                    default: begin
                        // Fold the rotor count into 0..q-1 in one step,
                        // carrying whole turns into the shaft count
                        r = rotor_turns;
                        if (r >= q) begin
                            k = r / q;
                            r = r - k * q;
                            shaft_turns = shaft_turns + k;
                        end else if (r < 0) begin
                            k = (-r + q - 1) / q;
                            r = r + k * q;
                            shaft_turns = shaft_turns - k;
                        end
                        rotor_turns = r[8:0];
                        held_angle  = shaft_angle_of(r, raw, q);
                        w.updated   = 1'b1;
                    end
                endcase
            end else begin
                case (w.wrap)
                    mtat_pkg::WRAP_REV: shaft_turns = shaft_turns - 1;
                    mtat_pkg::WRAP_FWD: shaft_turns = shaft_turns + 1;
                    default: begin
                        held_angle = shaft_angle_of(0, raw, q);
                        w.updated  = 1'b1;
                    end
                endcase
            end
        end
        w.angle  = held_angle;
        w.rotor  = rotor_turns;
        w.shaft  = shaft_turns;
        w.frames = frame_count;
        expected_words.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // Frame sender: bursts of random length with random gaps between
    // ------------------------------------------------------------------
    task automatic send_frame(input t_frame f);
        int gap;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                // Mostly short gaps, now and then one that spans a whole frame
                gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 70))
                                                  : int'($urandom_range(1, 4));
                burst_left = int'($urandom_range(1, 12));
                frame_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end else begin
                burst_left--;
            end
        end
        frame_ch.valid             <= 1'b1;
        frame_ch.angle_high_byte   <= f.angle_hi;
        frame_ch.angle_low_byte    <= f.angle_lo;
        frame_ch.speed_high_byte   <= f.speed_hi;
        frame_ch.speed_low_byte    <= f.speed_lo;
        frame_ch.current_high_byte <= f.current_hi;
        frame_ch.current_low_byte  <= f.current_lo;
        @(posedge clk);
        while (!frame_ch.ready) @(posedge clk);
        track_frame(f);
    endtask

    task automatic send_angle(input logic [15:0] angle);
        send_frame(make_frame(angle, 16'($urandom), 16'($urandom)));
    endtask

    // Drop valid and hold until every queued word has come back
    task automatic drain_results();
        frame_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register once the frame channel has gone idle
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            mtat_pkg::CFG_MOTOR_KIND: kind_reg  = data[1:0];
            mtat_pkg::CFG_RATIO:      ratio_reg = data[7:0];
            mtat_pkg::CFG_WRAP_HIGH:  high_reg  = data[12:0];
            mtat_pkg::CFG_WRAP_LOW:   low_reg   = data[12:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] kind, input logic [7:0] ratio,
                              input logic [12:0] high, input logic [12:0] low);
        drain_results();
        write_reg(mtat_pkg::CFG_MOTOR_KIND, 16'(kind));
        write_reg(mtat_pkg::CFG_RATIO, 16'(ratio));
        write_reg(mtat_pkg::CFG_WRAP_HIGH, 16'(high));
        write_reg(mtat_pkg::CFG_WRAP_LOW, 16'(low));
    endtask

    // Next encoder sample of a random walk; drift picks the spin direction
    task automatic walk_frame(input int drift, output t_frame f);
        int          pick;
        int          step;
        logic [15:0] angle;
        pick = int'($urandom_range(0, 9));
        if (pick == 0) begin
            // Noise: anywhere in the 16-bit field, past one turn too
            angle    = 16'($urandom);
            walk_pos = int'(angle) % COUNTS;
        end else if (pick == 1) begin
            walk_pos = int'($urandom_range(0, COUNTS - 1));
            angle    = 16'(walk_pos);
        end else begin
            step = int'($urandom_range(0, 1200)) - 600;
            if (drift > 0) begin
                step = step + int'($urandom_range(1000, 2800));
            end else if (drift < 0) begin
                step = step - int'($urandom_range(1000, 2800));
            end else if ($urandom_range(0, 1) == 1) begin
                step = step + int'($urandom_range(0, 2800));
            end else begin
                step = step - int'($urandom_range(0, 2800));
            end
            walk_pos = ((walk_pos + step) % COUNTS + COUNTS) % COUNTS;
            angle    = 16'(walk_pos);
        end
        f = make_frame(angle, 16'($urandom), 16'($urandom));
    endtask

    // Run n walk frames; at pause_at hold the sender until all words are back
    task automatic run_walk(input int n, input int drift, input int pause_at);
        t_frame f;
        for (int i = 0; i < n; i++) begin
            walk_frame(drift, f);
            send_frame(f);
            if (i == pause_at) drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default geared setup: first frame, both crossings, fold below zero
    task automatic test_power_on_crossings();
        send_frame(make_frame(16'd8191, 16'h7FFF, 16'h8000)); // first frame, near top
        send_frame(make_frame(16'd0, 16'h8000, 16'h7FFF));    // forward crossing
        send_frame(make_frame(16'd100, 16'hFFFF, 16'h0000));  // recompute, rotor 1
        send_frame(make_frame(16'd7000, 16'h0000, 16'hFFFF)); // reverse crossing
        send_frame(make_frame(16'd7000, 16'h00FF, 16'hFF00));
        send_frame(make_frame(16'hFFFF, 16'h5555, 16'hAAAA)); // beyond one turn
        send_frame(make_frame(16'd0, 16'hAAAA, 16'h5555));    // forward from 0xFFFF
        send_angle(16'd1499);                                 // just below low level
        send_angle(16'd6701);                                 // reverse at the edges
        send_angle(16'd6700);                                 // at the high level
        send_angle(16'd1000);
        send_angle(16'd8000);                                 // reverse, rotor to -1
        send_angle(16'd8100);                                 // fold -1 up, shaft -1
        drain_results();
    endtask

    // Register extremes, masking, ignored kinds and direct drive crossings
    task automatic test_register_extremes();
        drain_results();
        write_reg(mtat_pkg::CFG_RATIO, 16'd0);                // zero ratio acts as one
        send_angle(16'd2000);
        send_angle(16'd3000);
        write_reg(mtat_pkg::CFG_RATIO, 16'd255);
        send_angle(16'd4000);
        write_reg(mtat_pkg::CFG_WRAP_HIGH, 16'd0);
        write_reg(mtat_pkg::CFG_WRAP_LOW, 16'd8191);
        send_angle(16'd5000);
        send_angle(16'd0);
        send_angle(16'd5000);
        write_reg(mtat_pkg::CFG_WRAP_HIGH, 16'd8191);
        write_reg(mtat_pkg::CFG_WRAP_LOW, 16'd0);
        send_angle(16'hFFFF);
        send_angle(16'd0);
        drain_results();
        // Every bit set: kind lands on the spare code and frames are ignored
        write_reg(mtat_pkg::CFG_MOTOR_KIND, ALL_ONES);
        write_reg(mtat_pkg::CFG_RATIO, ALL_ONES);
        write_reg(mtat_pkg::CFG_WRAP_HIGH, ALL_ONES);
        write_reg(mtat_pkg::CFG_WRAP_LOW, ALL_ONES);
        send_angle(16'd1234);
        send_angle(16'hFFFF);
        set_config(mtat_pkg::KIND_DIRECT, mtat_pkg::RATIO_RST,
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
        send_angle(16'd8000);
        send_angle(16'd10);                                   // forward, shaft +1
        send_angle(16'd8000);                                 // reverse, shaft -1
        send_angle(16'd4096);
        drain_results();
        write_reg(CFG_UNUSED_LO, ALL_ONES);
        write_reg(CFG_UNUSED_HI, ALL_ONES);
        send_angle(16'd4097);
        drain_results();
        write_reg(mtat_pkg::CFG_MOTOR_KIND, 16'(mtat_pkg::KIND_NONE));
        send_angle(16'd100);
        set_config(mtat_pkg::KIND_GEARED, mtat_pkg::RATIO_RST,
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
    endtask

    task automatic test_geared_tracking();
        run_walk(300, 0, 150);
    endtask

    // Climb the rotor count under the largest ratio, then drop the ratio so
    // the next update folds many rotor turns into the shaft count at once
    task automatic test_ratio_drop_fold();
        set_config(mtat_pkg::KIND_GEARED, 8'd255,
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
        run_walk(350, 1, -1);
        set_config(mtat_pkg::KIND_GEARED, 8'd7,
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
        run_walk(150, 1, -1);
    endtask

    // Direct drive with no idling on either side
    task automatic test_direct_drive();
        set_config(mtat_pkg::KIND_DIRECT, 8'($urandom_range(1, 255)),
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
        sender_bursty   = 1'b0;
        receiver_stalls = 1'b0;
        run_walk(250, 0, -1);
        sender_bursty   = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_reverse_spin();
        set_config(mtat_pkg::KIND_GEARED, 8'd1,
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
        run_walk(200, -1, -1);
        set_config(mtat_pkg::KIND_GEARED, 8'd0,
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
        run_walk(100, 0, 50);
    endtask

    task automatic test_ignored_frames();
        set_config(mtat_pkg::KIND_NONE, mtat_pkg::RATIO_RST,
                   mtat_pkg::WRAP_HIGH_RST, mtat_pkg::WRAP_LOW_RST);
        run_walk(20, 0, -1);
        write_reg(mtat_pkg::CFG_MOTOR_KIND, 16'(KIND_SPARE));
        run_walk(20, 0, -1);
    endtask

    // Random kinds, ratios and wrap levels, one walk per setting
    task automatic test_random_settings();
        logic [1:0]  kind;
        logic [7:0]  ratio;
        logic [12:0] high;
        logic [12:0] low;
        for (int p = 0; p < 6; p++) begin
            kind = ($urandom_range(0, 3) == 0) ? mtat_pkg::KIND_DIRECT
                                               : mtat_pkg::KIND_GEARED;
            case ($urandom_range(0, 3))
                0:       ratio = 8'($urandom_range(0, 3));
                1:       ratio = 8'd255;
                default: ratio = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 2) == 0) begin
                high = 13'($urandom);
                low  = 13'($urandom);
            end else begin
                high = 13'($urandom_range(4000, 8191));
                low  = 13'($urandom_range(0, 4000));
            end
            set_config(kind, ratio, high, low);
            run_walk(80, int'($urandom_range(0, 2)) - 1, 40);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint want,
                               input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        t_tracker_word w;
        if (expected_words.size() == 0) begin
            $error("result word with no frame pending");
            mismatches++;
        end else begin
            w = expected_words.pop_front();
            check_field("frame_taken", w.taken, res_ch.frame_taken);
            check_field("shaft_angle", w.angle, res_ch.shaft_angle);
            check_field("angle_updated", w.updated, res_ch.angle_updated);
            check_field("wrap_event", w.wrap, res_ch.wrap_event);
            check_field("speed_value", w.speed, res_ch.speed_value);
            check_field("current_value", w.current, res_ch.current_value);
            check_field("rotor_turn_count", w.rotor, res_ch.rotor_turn_count);
            check_field("shaft_turn_count", w.shaft, res_ch.shaft_turn_count);
            check_field("frames_seen", w.frames, res_ch.frames_seen);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) check_word();
        stall_lfsr  <= {stall_lfsr[14:0],
                        stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
        cycle_count <= cycle_count + 1;
        // Short random stalls plus a periodic stall while cycle_count[8:5] is 4'b1011
        res_ch.ready <= !(receiver_stalls &&
                          (stall_lfsr[1:0] == 2'b00 || cycle_count[8:5] == 4'b1011));
    end

    // Watchdog: end the run when no channel moves a word for too long
    always @(posedge clk) begin
        if (!rst_n || (frame_ch.valid && frame_ch.ready) ||
            (res_ch.valid && res_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n                      <= 1'b0;
        frame_ch.valid             <= 1'b0;
        frame_ch.angle_high_byte   <= '0;
        frame_ch.angle_low_byte    <= '0;
        frame_ch.speed_high_byte   <= '0;
        frame_ch.speed_low_byte    <= '0;
        frame_ch.current_high_byte <= '0;
        frame_ch.current_low_byte  <= '0;
        cfg_ch.valid               <= 1'b0;
        cfg_ch.index               <= '0;
        cfg_ch.data                <= '0;

        // Reset state of the model: default configuration, counts cleared
        kind_reg    = mtat_pkg::KIND_RST;
        ratio_reg   = mtat_pkg::RATIO_RST;
        high_reg    = mtat_pkg::WRAP_HIGH_RST;
        low_reg     = mtat_pkg::WRAP_LOW_RST;
        angle_now   = '0;
        seen_first  = 1'b0;
        rotor_turns = '0;
        shaft_turns = '0;
        held_angle  = '0;
        frame_count = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_crossings();
        test_register_extremes();
        test_geared_tracking();
        test_ratio_drop_fold();
        test_direct_drive();
        test_reverse_spin();
        test_ignored_frames();
        test_random_settings();

        drain_results();
        repeat (LATENCY_TAIL) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mtat_pkg.sv
src/mtat_ifs.sv
src/multiturn_encoder_angle_tracker.sv
sim/testbench.sv
